FILE: hw/rtl/timestamp_ordered_log_replay_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the log replay core
// Each macro is active in simulation and compiles to nothing when SYNTH is set.
// The macros expect clk and arst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_ORDERED_LOG_REPLAY_CORE_MACROS_SVH
`define TIMESTAMP_ORDERED_LOG_REPLAY_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define LRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define LRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRP_ASSERT_NOW(label, ante, cons, msg)
`define LRP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Constants, codes and types shared by the log replay core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

	localparam int THREADS     = 8;
	localparam int LOG_DEPTH   = 256;
	localparam int WRITE_LIMIT = 32;

	localparam int THR_W   = $clog2(THREADS);
	localparam int ADDR_W  = $clog2(LOG_DEPTH);
	localparam int POS_W   = ADDR_W + 1;
	localparam int OPEN_W  = $clog2(WRITE_LIMIT + 1);
	localparam int MADDR_W = THR_W + ADDR_W;
	localparam int HW_W    = 17;
	localparam int IDX_W   = 16;
	localparam int DATA_W  = 64;
	localparam int TS_W    = 63;

	localparam logic [HW_W-1:0] HEAP_WORDS_RESET = HW_W'(65536);

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_REPLAY = 2'd2,
		CMD_CLEAR  = 2'd3
	} lrp_cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_RANGE     = 3'd2,
		ST_NONE      = 3'd3,
		ST_TOO_LONG  = 3'd4
	} lrp_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_THR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PICK,
		S_STR_RD,
		S_STR_OUT
	} lrp_state_t;

	typedef struct packed {
		logic              marker;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] payload;
	} lrp_entry_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [THR_W-1:0]  thread;
		logic              write_valid;
		logic [IDX_W-1:0]  write_index;
		logic [DATA_W-1:0] write_value;
		logic [TS_W-1:0]   commit_stamp;
		logic              last;
	} lrp_res_t;

	typedef struct packed {
		logic               wr_en;
		logic [MADDR_W-1:0] wr_addr;
		lrp_entry_t         wr_entry;
		logic               rd_en;
		logic [MADDR_W-1:0] rd_addr;
	} lrp_mem_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrp_req_if.sv
// ----------------------------------------------------------------------------
// lrp_req_if
// Command channel of the log replay core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lrp_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [lrp_pkg::THR_W-1:0]  thread;
	logic [lrp_pkg::IDX_W-1:0]  heap_index;
	logic [lrp_pkg::DATA_W-1:0] write_data;
	logic [lrp_pkg::TS_W-1:0]   stamp;

	modport source (output valid, command, thread, heap_index, write_data, stamp,
		input ready);
	modport sink (input valid, command, thread, heap_index, write_data, stamp,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lrp_rsp_if.sv
// ----------------------------------------------------------------------------
// lrp_rsp_if
// Result channel of the log replay core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lrp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [lrp_pkg::THR_W-1:0]  replayed_thread;
	logic                       write_valid;
	logic [lrp_pkg::IDX_W-1:0]  write_index;
	logic [lrp_pkg::DATA_W-1:0] write_value;
	logic [lrp_pkg::TS_W-1:0]   commit_stamp;
	logic                       last;

	modport source (output valid, status, replayed_thread, write_valid, write_index,
		write_value, commit_stamp, last, input ready);
	modport sink (input valid, status, replayed_thread, write_valid, write_index,
		write_value, commit_stamp, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/timestamp_ordered_log_replay_core.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_log_replay_core
// Per-thread redo logs with replay of closed transactions in timestamp order.
// ----------------------------------------------------------------------------
// Usage:
//   req carries commands: append write, append commit marker, replay, clear.
//   rsp carries results; every command ends with a result whose last is 1.
//   cfg_valid/cfg_data write heap_words; cfg_ready is always high. Write it
//   only while the core is idle.
// Sequencing:
//   Appends and clear complete in the idle state; their result sits in the output
//   register on the next cycle and the next command may transfer then if rsp is ready.
//   A replay runs a sequencer over the single log memory read port: it visits
//   each thread in turn and reads entries from its head to find the oldest
//   commit marker of each thread with closed work, then streams out each write
//   of the transaction with the smallest commit stamp. A transaction holds at
//   most 32 writes and there are 8 threads. req.ready is low during a replay.
// Reset:
//   arst_n empties all logs and restores heap_words to 65536. Log memory
//   contents are not cleared; only entries between head and tail are read.
// Backpressure:
//   While rsp is stalled the result holds and the sequencer waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_ordered_log_replay_core_macros.svh"

module timestamp_ordered_log_replay_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lrp_req_if.sink                          req,
	lrp_rsp_if.source                        rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lrp_pkg::HW_W-1:0]    cfg_data
);

	localparam int THR_W = lrp_pkg::THR_W;
	localparam int POS_W = lrp_pkg::POS_W;

	lrp_pkg::lrp_state_t state_q, state_d;

	logic [lrp_pkg::HW_W-1:0]   heap_words_q;
	logic [POS_W-1:0]           head_q   [lrp_pkg::THREADS];
	logic [POS_W-1:0]           tail_q   [lrp_pkg::THREADS];
	logic [lrp_pkg::OPEN_W-1:0] open_q   [lrp_pkg::THREADS];
	logic [POS_W-1:0]           closed_q [lrp_pkg::THREADS];

	logic [THR_W-1:0]           thr_q;
	logic [POS_W-1:0]           pos_q;
	logic                       found_q;
	logic [THR_W-1:0]           best_thr_q;
	logic [lrp_pkg::TS_W-1:0]   best_ts_q;
	logic [POS_W-1:0]           best_pos_q;

	logic                       res_valid_q;
	lrp_pkg::lrp_res_t          res_q, res_d;
	logic                       out_load;

	lrp_pkg::lrp_mem_ctl_t      mem_ctl;
	lrp_pkg::lrp_entry_t        rd_entry;

	logic free, acc, thr_last, last_w, pick_empty, better;
	logic [THR_W-1:0] req_thr;
	logic [1:0] req_cmd;
	logic wr_ok, mk_ok;
	lrp_pkg::lrp_status_t app_status;

	lrp_log_mem u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.rd_entry (rd_entry)
	);

	assign cfg_ready = 1'b1;
	assign free      = !res_valid_q || rsp.ready;
	assign req.ready = (state_q == lrp_pkg::S_IDLE) && free;
	assign acc       = req.valid && req.ready;
	assign req_thr   = req.thread;
	assign req_cmd   = req.command;
	assign thr_last  = (thr_q == THR_W'(lrp_pkg::THREADS - 1));
	assign last_w    = ((pos_q + POS_W'(1)) == best_pos_q);
	assign pick_empty = (head_q[best_thr_q] == best_pos_q);
	assign better    = !found_q || (rd_entry.payload[lrp_pkg::TS_W-1:0] < best_ts_q);

	// append checks, in refusal order
	always_comb begin
		wr_ok = 1'b0;
		mk_ok = 1'b0;
		app_status = lrp_pkg::ST_OK;
		if (req_cmd == lrp_pkg::CMD_WRITE) begin
			if (tail_q[req_thr] >= POS_W'(lrp_pkg::LOG_DEPTH - 1)) begin
				app_status = lrp_pkg::ST_FULL;
			end else if ({1'b0, req.heap_index} >= heap_words_q) begin
				app_status = lrp_pkg::ST_RANGE;
			end else if (open_q[req_thr] >= lrp_pkg::OPEN_W'(lrp_pkg::WRITE_LIMIT)) begin
				app_status = lrp_pkg::ST_TOO_LONG;
			end else begin
				wr_ok = 1'b1;
			end
		end else if (req_cmd == lrp_pkg::CMD_COMMIT) begin
			if (tail_q[req_thr] >= POS_W'(lrp_pkg::LOG_DEPTH)) begin
				app_status = lrp_pkg::ST_FULL;
			end else begin
				mk_ok = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrp_pkg::S_IDLE: begin
				if (acc && req_cmd == lrp_pkg::CMD_REPLAY) begin
					state_d = lrp_pkg::S_SCAN_THR;
				end
			end
			lrp_pkg::S_SCAN_THR: begin
				if (closed_q[thr_q] != '0) begin
					state_d = lrp_pkg::S_SCAN_RD;
				end else if (thr_last) begin
					state_d = lrp_pkg::S_PICK;
				end
			end
			lrp_pkg::S_SCAN_RD: state_d = lrp_pkg::S_SCAN_CHK;
			lrp_pkg::S_SCAN_CHK: begin
				if (!rd_entry.marker) begin
					state_d = lrp_pkg::S_SCAN_RD;
				end else if (thr_last) begin
					state_d = lrp_pkg::S_PICK;
				end else begin
					state_d = lrp_pkg::S_SCAN_THR;
				end
			end
			lrp_pkg::S_PICK: begin
				if (free) begin
					state_d = (!found_q || pick_empty) ? lrp_pkg::S_IDLE : lrp_pkg::S_STR_RD;
				end
			end
			lrp_pkg::S_STR_RD: state_d = lrp_pkg::S_STR_OUT;
			lrp_pkg::S_STR_OUT: begin
				if (free) begin
					state_d = last_w ? lrp_pkg::S_IDLE : lrp_pkg::S_STR_RD;
				end
			end
			default: state_d = lrp_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		res_d    = '0;
		out_load = 1'b0;
		mem_ctl  = '0;
		mem_ctl.wr_addr = {req_thr, tail_q[req_thr][lrp_pkg::ADDR_W-1:0]};
		mem_ctl.rd_addr = {thr_q, pos_q[lrp_pkg::ADDR_W-1:0]};
		if (req_cmd == lrp_pkg::CMD_COMMIT) begin
			mem_ctl.wr_entry.marker  = 1'b1;
			mem_ctl.wr_entry.payload = {1'b0, req.stamp};
		end else begin
			mem_ctl.wr_entry.index   = req.heap_index;
			mem_ctl.wr_entry.payload = req.write_data;
		end
		res_d.last = 1'b1;
		case (state_q)
			lrp_pkg::S_IDLE: begin
				if (acc && req_cmd != lrp_pkg::CMD_REPLAY) begin
					out_load      = 1'b1;
					res_d.status  = app_status;
					mem_ctl.wr_en = wr_ok || mk_ok;
				end
			end
			lrp_pkg::S_SCAN_RD: mem_ctl.rd_en = 1'b1;
			lrp_pkg::S_STR_RD:  mem_ctl.rd_en = 1'b1;
			lrp_pkg::S_PICK: begin
				if (free && !found_q) begin
					out_load     = 1'b1;
					res_d.status = lrp_pkg::ST_NONE;
				end else if (free && pick_empty) begin
					out_load           = 1'b1;
					res_d.thread       = best_thr_q;
					res_d.commit_stamp = best_ts_q;
				end
			end
			lrp_pkg::S_STR_OUT: begin
				if (free) begin
					out_load           = 1'b1;
					res_d.thread       = best_thr_q;
					res_d.write_valid  = 1'b1;
					res_d.write_index  = rd_entry.index;
					res_d.write_value  = rd_entry.payload;
					res_d.commit_stamp = best_ts_q;
					res_d.last         = last_w;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lrp_pkg::S_IDLE;
			res_valid_q  <= 1'b0;
			heap_words_q <= lrp_pkg::HEAP_WORDS_RESET;
			found_q      <= 1'b0;
			thr_q        <= '0;
			for (int t = 0; t < lrp_pkg::THREADS; t++) begin
				head_q[t]   <= '0;
				tail_q[t]   <= '0;
				open_q[t]   <= '0;
				closed_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				heap_words_q <= cfg_data;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				lrp_pkg::S_IDLE: begin
					if (acc) begin
						if (req_cmd == lrp_pkg::CMD_REPLAY) begin
							thr_q   <= '0;
							found_q <= 1'b0;
						end else if (req_cmd == lrp_pkg::CMD_CLEAR) begin
							for (int t = 0; t < lrp_pkg::THREADS; t++) begin
								head_q[t]   <= '0;
								tail_q[t]   <= '0;
								open_q[t]   <= '0;
								closed_q[t] <= '0;
							end
						end else if (wr_ok) begin
							tail_q[req_thr] <= tail_q[req_thr] + POS_W'(1);
							open_q[req_thr] <= open_q[req_thr] + lrp_pkg::OPEN_W'(1);
						end else if (mk_ok) begin
							tail_q[req_thr]   <= tail_q[req_thr] + POS_W'(1);
							open_q[req_thr]   <= '0;
							closed_q[req_thr] <= closed_q[req_thr] + POS_W'(1);
						end
					end
				end
				lrp_pkg::S_SCAN_THR: begin
					pos_q <= head_q[thr_q];
					if (closed_q[thr_q] == '0) begin
						thr_q <= thr_q + THR_W'(1);
					end
				end
				lrp_pkg::S_SCAN_CHK: begin
					if (rd_entry.marker) begin
						if (better) begin
							found_q    <= 1'b1;
							best_thr_q <= thr_q;
							best_ts_q  <= rd_entry.payload[lrp_pkg::TS_W-1:0];
							best_pos_q <= pos_q;
						end
						thr_q <= thr_q + THR_W'(1);
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				lrp_pkg::S_PICK: begin
					thr_q <= best_thr_q;
					pos_q <= head_q[best_thr_q];
					if (free && found_q && pick_empty) begin
						head_q[best_thr_q]   <= best_pos_q + POS_W'(1);
						closed_q[best_thr_q] <= closed_q[best_thr_q] - POS_W'(1);
					end
				end
				lrp_pkg::S_STR_OUT: begin
					if (free) begin
						pos_q <= pos_q + POS_W'(1);
						if (last_w) begin
							head_q[thr_q]   <= best_pos_q + POS_W'(1);
							closed_q[thr_q] <= closed_q[thr_q] - POS_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid           = res_valid_q;
	assign rsp.status          = res_q.status;
	assign rsp.replayed_thread = res_q.thread;
	assign rsp.write_valid     = res_q.write_valid;
	assign rsp.write_index     = res_q.write_index;
	assign rsp.write_value     = res_q.write_value;
	assign rsp.commit_stamp    = res_q.commit_stamp;
	assign rsp.last            = res_q.last;

	`LRP_ASSERT_NOW(a_scan_has_work, state_q == lrp_pkg::S_SCAN_CHK, closed_q[thr_q] != '0, "scan on empty thread")
	`LRP_ASSERT_NOW(a_stream_below_marker, state_q == lrp_pkg::S_STR_RD, pos_q < best_pos_q, "read past marker")
	`LRP_ASSERT_NOW(a_closed_le_tail, state_q == lrp_pkg::S_PICK && found_q, closed_q[best_thr_q] <= tail_q[best_thr_q], "closed over fill")
	`LRP_ASSERT_NEXT(a_load_sets_valid, out_load, res_valid_q, "loaded result not presented")

endmodule

`default_nettype wire

FILE: hw/rtl/lrp_log_mem.sv
// ----------------------------------------------------------------------------
// lrp_log_mem
// Log entry storage for all threads: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrp_log_mem (
	input  wire logic                 clk,
	input  wire lrp_pkg::lrp_mem_ctl_t ctl,
	output lrp_pkg::lrp_entry_t       rd_entry
);

	localparam int DEPTH = lrp_pkg::THREADS * lrp_pkg::LOG_DEPTH;

	lrp_pkg::lrp_entry_t mem [DEPTH];
	lrp_pkg::lrp_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

`default_nettype wire

FILE: tb/timestamp_ordered_log_replay_core_tb.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_log_replay_core_tb
// Drives appends, commits, replays and clears into the log replay core with
// random bursts, gaps and result stalls, predicts every result from its own
// copy of the per-thread logs and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamp_ordered_log_replay_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int THREADS     = lrp_pkg::THREADS;
	localparam int LOG_DEPTH   = lrp_pkg::LOG_DEPTH;
	localparam int WRITE_LIMIT = lrp_pkg::WRITE_LIMIT;
	localparam int THR_W  = lrp_pkg::THR_W;
	localparam int HW_W   = lrp_pkg::HW_W;
	localparam int IDX_W  = lrp_pkg::IDX_W;
	localparam int DATA_W = lrp_pkg::DATA_W;
	localparam int TS_W   = lrp_pkg::TS_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [HW_W-1:0] cfg_data = '0;

	lrp_req_if req ();
	lrp_rsp_if rsp ();

	timestamp_ordered_log_replay_core u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted log state
	logic [DATA_W-1:0] log_payload [THREADS][LOG_DEPTH];
	logic [IDX_W-1:0]  log_index [THREADS][LOG_DEPTH];
	logic              log_marker [THREADS][LOG_DEPTH];
	int unsigned log_head [THREADS];
	int unsigned log_tail [THREADS];
	int unsigned open_writes [THREADS];
	int unsigned closed_txns [THREADS];
	logic [HW_W-1:0] heap_limit;

	lrp_pkg::lrp_res_t expected_results [$];
	int errors = 0;
	int accepted_items = 0;
	int replayed_writes = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit long_stall = 1'b0;
	bit stall_enable = 1'b1;

	initial begin
		req.valid = 1'b0;
		req.command = '0;
		req.thread = '0;
		req.heap_index = '0;
		req.write_data = '0;
		req.stamp = '0;
		rsp.ready = 1'b0;
	end

	function automatic lrp_pkg::lrp_res_t status_result(lrp_pkg::lrp_status_t st);
		lrp_pkg::lrp_res_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void clear_logs();
		for (int t = 0; t < THREADS; t++) begin
			log_head[t] = 0;
			log_tail[t] = 0;
			open_writes[t] = 0;
			closed_txns[t] = 0;
		end
	endfunction

	// Work out the results of one accepted command and queue them
	function automatic void predict_results(lrp_pkg::lrp_cmd_t cmd, int unsigned thr,
			logic [IDX_W-1:0] hidx, logic [DATA_W-1:0] data, logic [TS_W-1:0] ts);
		int best_t;
		int best_p;
		int unsigned pos;
		logic [TS_W-1:0] best_ts;
		lrp_pkg::lrp_res_t r;
		int n;
		best_t = -1;
		best_p = 0;
		best_ts = '0;
		n = 0;
		case (cmd)
			lrp_pkg::CMD_WRITE: begin
				if (log_tail[thr] + 1 >= LOG_DEPTH) begin
					expected_results.push_back(status_result(lrp_pkg::ST_FULL));
				end else if ({1'b0, hidx} >= heap_limit) begin
					expected_results.push_back(status_result(lrp_pkg::ST_RANGE));
				end else if (open_writes[thr] >= WRITE_LIMIT) begin
					expected_results.push_back(status_result(lrp_pkg::ST_TOO_LONG));
				end else begin
					log_payload[thr][log_tail[thr]] = data;
					log_index[thr][log_tail[thr]] = hidx;
					log_marker[thr][log_tail[thr]] = 1'b0;
					log_tail[thr]++;
					open_writes[thr]++;
					expected_results.push_back(status_result(lrp_pkg::ST_OK));
				end
			end
			lrp_pkg::CMD_COMMIT: begin
				if (log_tail[thr] >= LOG_DEPTH) begin
					expected_results.push_back(status_result(lrp_pkg::ST_FULL));
				end else begin
					log_payload[thr][log_tail[thr]] = {1'b0, ts};
					log_index[thr][log_tail[thr]] = '0;
					log_marker[thr][log_tail[thr]] = 1'b1;
					log_tail[thr]++;
					open_writes[thr] = 0;
					closed_txns[thr]++;
					expected_results.push_back(status_result(lrp_pkg::ST_OK));
				end
			end
			lrp_pkg::CMD_CLEAR: begin
				clear_logs();
				expected_results.push_back(status_result(lrp_pkg::ST_OK));
			end
			default: begin
				for (int t = 0; t < THREADS; t++) begin
					if (closed_txns[t] == 0)
						continue;
					pos = log_head[t];
					while (pos < log_tail[t] && !log_marker[t][pos])
						pos++;
					if (pos >= log_tail[t])
						continue;
					if (best_t < 0 || log_payload[t][pos][TS_W-1:0] < best_ts) begin
						best_t = t;
						best_p = pos;
						best_ts = log_payload[t][pos][TS_W-1:0];
					end
				end
				if (best_t < 0) begin
					expected_results.push_back(status_result(lrp_pkg::ST_NONE));
				end else begin
					for (int p = log_head[best_t]; p < best_p; p++) begin
						r = '0;
						r.status = lrp_pkg::ST_OK;
						r.thread = THR_W'(best_t);
						r.write_valid = 1'b1;
						r.write_index = log_index[best_t][p];
						r.write_value = log_payload[best_t][p];
						r.commit_stamp = best_ts;
						r.last = (p == best_p - 1);
						expected_results.push_back(r);
						n++;
					end
					if (n == 0) begin
						r = '0;
						r.status = lrp_pkg::ST_OK;
						r.thread = THR_W'(best_t);
						r.commit_stamp = best_ts;
						r.last = 1'b1;
						expected_results.push_back(r);
					end
					replayed_writes += n;
					log_head[best_t] = best_p + 1;
					closed_txns[best_t]--;
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// Receiver: stall pattern and result checking
	always @(posedge clk) begin
		lrp_pkg::lrp_res_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", rsp.status, 0);
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp.status != exp_r.status)
					report_mismatch("status", rsp.status, exp_r.status);
				if (rsp.replayed_thread != exp_r.thread)
					report_mismatch("replayed_thread", rsp.replayed_thread, exp_r.thread);
				if (rsp.write_valid != exp_r.write_valid)
					report_mismatch("write_valid", rsp.write_valid, exp_r.write_valid);
				if (rsp.write_index != exp_r.write_index)
					report_mismatch("write_index", rsp.write_index, exp_r.write_index);
				if (rsp.write_value != exp_r.write_value)
					report_mismatch("write_value", rsp.write_value, exp_r.write_value);
				if (rsp.commit_stamp != exp_r.commit_stamp)
					report_mismatch("commit_stamp", rsp.commit_stamp, exp_r.commit_stamp);
				if (rsp.last != exp_r.last)
					report_mismatch("last", rsp.last, exp_r.last);
			end
		end
		if (long_stall)
			rsp.ready <= 1'b0;
		else if (!stall_enable)
			rsp.ready <= 1'b1;
		else
			rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || long_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one command and hold it until the core takes it; a burst keeps
	// valid high, its end drops valid for a random gap
	task automatic send_command(lrp_pkg::lrp_cmd_t cmd, int unsigned thr,
			logic [IDX_W-1:0] hidx, logic [DATA_W-1:0] data, logic [TS_W-1:0] ts);
		int gap;
		if (burst_left == 0)
			burst_left = $urandom_range(1, 12);
		burst_left--;
		req.valid <= 1'b1;
		req.command <= cmd;
		req.thread <= THR_W'(thr);
		req.heap_index <= hidx;
		req.write_data <= data;
		req.stamp <= ts;
		do @(posedge clk); while (!req.ready);
		predict_results(cmd, thr, hidx, data, ts);
		accepted_items++;
		if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
			gap = $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid if a burst is still open
	task automatic end_burst();
		burst_left = 0;
		if (req.valid) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		end_burst();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_heap_words(logic [HW_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		heap_limit = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [TS_W-1:0] rand_stamp();
		logic [DATA_W-1:0] v;
		v = rand64();
		case ($urandom_range(0, 3))
			0: return v[TS_W-1:0];
			1: return TS_W'($urandom_range(0, 7));
			2: return {TS_W{1'b1}} - TS_W'($urandom_range(0, 3));
			default: return TS_W'(v[15:0]);
		endcase
	endfunction

	task automatic test_directed();
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_WRITE, 0, 16'hFFFF, '1, '0);
		send_command(lrp_pkg::CMD_WRITE, 0, 16'h0000, '0, '0);
		send_command(lrp_pkg::CMD_COMMIT, 0, '0, '0, {TS_W{1'b1}});
		send_command(lrp_pkg::CMD_COMMIT, 7, '0, '0, {TS_W{1'b1}});
		send_command(lrp_pkg::CMD_WRITE, 3, 16'h1234, 64'hA5A5_5A5A_0F0F_F0F0, '0);
		send_command(lrp_pkg::CMD_COMMIT, 3, '0, '0, '0);
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		// open transaction past the write limit
		for (int i = 0; i <= WRITE_LIMIT; i++)
			send_command(lrp_pkg::CMD_WRITE, 5, IDX_W'(i), rand64(), '0);
		send_command(lrp_pkg::CMD_COMMIT, 5, '0, '0, TS_W'(9));
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_CLEAR, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
	endtask

	task automatic test_heap_limits();
		write_heap_words(HW_W'(0));
		send_command(lrp_pkg::CMD_WRITE, 1, 16'h0000, rand64(), '0);
		write_heap_words(HW_W'(1));
		send_command(lrp_pkg::CMD_WRITE, 1, 16'h0000, rand64(), '0);
		send_command(lrp_pkg::CMD_WRITE, 1, 16'h0001, rand64(), '0);
		write_heap_words({HW_W{1'b1}});
		send_command(lrp_pkg::CMD_WRITE, 1, 16'hFFFF, rand64(), '0);
		send_command(lrp_pkg::CMD_COMMIT, 1, '0, '0, rand_stamp());
		send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		write_heap_words(HW_W'(100));
		send_command(lrp_pkg::CMD_WRITE, 1, 16'd99, rand64(), '0);
		send_command(lrp_pkg::CMD_WRITE, 1, 16'd100, rand64(), '0);
	endtask

	// Fill one log to its end to reach both log-full answers
	task automatic test_log_full();
		send_command(lrp_pkg::CMD_CLEAR, 0, '0, '0, '0);
		for (int i = 0; i < LOG_DEPTH + 2; i++) begin
			if (i % 20 == 19)
				send_command(lrp_pkg::CMD_COMMIT, 2, '0, '0, rand_stamp());
			else
				send_command(lrp_pkg::CMD_WRITE, 2, IDX_W'($urandom_range(0, 99)),
					rand64(), '0);
		end
		send_command(lrp_pkg::CMD_COMMIT, 2, '0, '0, rand_stamp());
		send_command(lrp_pkg::CMD_COMMIT, 2, '0, '0, rand_stamp());
		for (int i = 0; i < 3; i++)
			send_command(lrp_pkg::CMD_REPLAY, 0, '0, '0, '0);
		send_command(lrp_pkg::CMD_CLEAR, 0, '0, '0, '0);
	endtask

	// Mostly well-formed transactions interleaved across threads, with replays and clears
	task automatic test_random_traffic(int count);
		int pick;
		int unsigned thr;
		logic [IDX_W-1:0] hidx;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			thr = $urandom_range(0, THREADS - 1);
			hidx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom())
				: IDX_W'($urandom_range(0, heap_limit > 1 ? 1 : 0));
			if ($urandom_range(0, 1) != 0)
				hidx = IDX_W'($urandom());
			if (pick < 55)
				send_command(lrp_pkg::CMD_WRITE, thr, hidx, rand64(), '0);
			else if (pick < 72)
				send_command(lrp_pkg::CMD_COMMIT, thr, '0, '0, rand_stamp());
			else if (pick < 98)
				send_command(lrp_pkg::CMD_REPLAY, thr, hidx, rand64(), rand_stamp());
			else
				send_command(lrp_pkg::CMD_CLEAR, thr, hidx, rand64(), rand_stamp());
		end
	endtask

	// Hold the result side off while commands keep coming
	task automatic test_backpressure();
		fork
			begin
				long_stall = 1'b1;
				repeat (400) @(posedge clk);
				long_stall = 1'b0;
			end
			test_random_traffic(20);
		join
		drain_results();
	endtask

	initial begin
		heap_limit = lrp_pkg::HEAP_WORDS_RESET;
		clear_logs();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_heap_limits();
		test_log_full();
		write_heap_words(HW_W'(65536));
		stall_enable = 1'b0;
		test_random_traffic(20);
		stall_enable = 1'b1;
		test_backpressure();
		write_heap_words(HW_W'(40000));
		test_random_traffic(35);
		write_heap_words(HW_W'(65536));
		test_random_traffic(35);
		drain_results();
		$display("covered %0d commands, %0d replayed writes, heap limits 0 to max",
			accepted_items, replayed_writes);
		$display("with bursty input, stalled results and a long result hold-off");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

`default_nettype wire

FILE: tb/_unused_placeholder.sv
`timescale 1ns / 1ps
